### src/r5am_pkg.sv
// Shared constants, types and the divider step function for the RAID 5 address map.
// Used by the pipelined divider and the top level; depends on nothing else.
package r5am_pkg;

  localparam int SECTOR_W  = 32;
  localparam int SPU_W     = 13;
  localparam int ND_W      = 5;
  localparam int COL_W     = 4;
  localparam int MAX_DISKS = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 13;

  // Bits retired per pipeline stage of the divider (radix 16).
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = SECTOR_W / DIV_STEP;

  // Sideband carried beside a division: stripe, unit offset, partial column.
  localparam int SIDE_W = SECTOR_W + SPU_W + COL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTORS_PER_UNIT = 1'b0,
    REG_NUM_DISKS        = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SPU_W-1:0]    rem;
    logic [SECTOR_W-1:0] qd;
  } div_state_t;

  // Restoring division, DIV_STEP bits. qd holds the unconsumed dividend bits
  // at the top and the quotient bits collected so far at the bottom.
  function automatic div_state_t div_step(input div_state_t st,
                                          input logic [SPU_W-1:0] d);
    logic [SPU_W:0]      r;
    logic [SPU_W-1:0]    rem;
    logic [SECTOR_W-1:0] qd;
    rem = st.rem;
    qd  = st.qd;
    for (int i = 0; i < DIV_STEP; i++) begin
      r = {rem, qd[SECTOR_W-1]};
      if (r >= {1'b0, d}) begin
        r  = r - {1'b0, d};
        qd = {qd[SECTOR_W-2:0], 1'b1};
      end else begin
        qd = {qd[SECTOR_W-2:0], 1'b0};
      end
      rem = r[SPU_W-1:0];
    end
    div_step.rem = rem;
    div_step.qd  = qd;
  endfunction

endpackage

### src/r5am_div.sv
// Pipelined radix-16 restoring divider, one stage per four quotient bits.
// Depends on r5am_pkg for widths and the step function.
module r5am_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [r5am_pkg::SECTOR_W-1:0] dividend,
  input  logic [r5am_pkg::SPU_W-1:0]    divisor,
  input  logic [r5am_pkg::SIDE_W-1:0]   side_in,
  output logic                         out_valid,
  output logic [r5am_pkg::SECTOR_W-1:0] quot,
  output logic [r5am_pkg::SPU_W-1:0]    rem,
  output logic [r5am_pkg::SIDE_W-1:0]   side_out
);

  logic                         valid [r5am_pkg::DIV_STAGES];
  r5am_pkg::div_state_t         st    [r5am_pkg::DIV_STAGES];
  logic [r5am_pkg::SIDE_W-1:0]  side  [r5am_pkg::DIV_STAGES];

  // The divisor comes straight from configuration, which the user must keep stable
  // while any transaction is in flight; the block itself does not enforce it.
  for (genvar s = 0; s < r5am_pkg::DIV_STAGES; s++) begin : g_stage
    r5am_pkg::div_state_t prev;
    logic                 prev_valid;
    logic [r5am_pkg::SIDE_W-1:0] prev_side;

    if (s == 0) begin : g_first
      assign prev.rem   = '0;
      assign prev.qd    = dividend;
      assign prev_valid = in_valid;
      assign prev_side  = side_in;
    end else begin : g_next
      assign prev       = st[s-1];
      assign prev_valid = valid[s-1];
      assign prev_side  = side[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else begin
        valid[s] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      st[s]   <= r5am_pkg::div_step(prev, divisor);
      side[s] <= prev_side;
    end
  end

  assign out_valid = valid[r5am_pkg::DIV_STAGES-1];
  assign quot      = st[r5am_pkg::DIV_STAGES-1].qd;
  assign rem       = st[r5am_pkg::DIV_STAGES-1].rem;
  assign side_out  = side[r5am_pkg::DIV_STAGES-1];

endmodule

### src/raid5_address_map.sv
// Top level of the RAID 5 left-symmetric address map: config, three dividers, output.
// Depends on r5am_pkg and r5am_div.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   request  | start / busy        | raid_sector
//   result   | done (strobe)       | data_col, parity_col, disk_sector,
//            |                     | stripe_first_disk
//   config   | cfg_we              | cfg_index, cfg_data
//
// A transaction is taken every cycle; busy is always low. Each result passes
// through three 8-stage dividers (sector by unit size, unit by data disks,
// stripe by disks), one multiply stage and one output stage. Reset clears
// all valid bits and loads unit size 128 and 5 disks. The receiver cannot
// stall, so the pipeline never holds.
module raid5_address_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [r5am_pkg::SECTOR_W-1:0] raid_sector,
  output logic                          done,
  output logic [r5am_pkg::COL_W-1:0]    data_col,
  output logic [r5am_pkg::COL_W-1:0]    parity_col,
  output logic [r5am_pkg::SECTOR_W-1:0] disk_sector,
  output logic [r5am_pkg::COL_W-1:0]    stripe_first_disk,
  input  logic                          cfg_we,
  input  logic [r5am_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r5am_pkg::CFG_W-1:0]    cfg_data
);

  logic [r5am_pkg::SPU_W-1:0] sectors_per_unit;
  logic [r5am_pkg::ND_W-1:0]  num_disks;
  logic [r5am_pkg::SPU_W-1:0] spu_eff;
  logic [r5am_pkg::ND_W-1:0]  nd_eff;
  logic [r5am_pkg::ND_W-1:0]  ndata;

  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_unit <= r5am_pkg::SPU_W'(128);
      num_disks        <= r5am_pkg::ND_W'(5);
    end else if (cfg_we) begin
      case (cfg_index)
        r5am_pkg::REG_SECTORS_PER_UNIT: sectors_per_unit <= cfg_data[r5am_pkg::SPU_W-1:0];
        r5am_pkg::REG_NUM_DISKS:        num_disks <= cfg_data[r5am_pkg::ND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    spu_eff = (sectors_per_unit == '0) ? r5am_pkg::SPU_W'(1) : sectors_per_unit;
    if (num_disks < r5am_pkg::ND_W'(2)) begin
      nd_eff = r5am_pkg::ND_W'(2);
    end else if (num_disks > r5am_pkg::ND_W'(r5am_pkg::MAX_DISKS)) begin
      nd_eff = r5am_pkg::ND_W'(r5am_pkg::MAX_DISKS);
    end else begin
      nd_eff = num_disks;
    end
    ndata = nd_eff - r5am_pkg::ND_W'(1);
  end

  assign busy = 1'b0;

  // Unit number and offset within the unit.
  logic                          d1_valid;
  logic [r5am_pkg::SECTOR_W-1:0] unit;
  logic [r5am_pkg::SPU_W-1:0]    offset;

  r5am_div u_div_unit (
    .clk(clk), .rst(rst),
    .in_valid(start & ~busy),
    .dividend(raid_sector),
    .divisor(spu_eff),
    .side_in('0),
    .out_valid(d1_valid),
    .quot(unit),
    .rem(offset),
    .side_out()
  );

  // Stripe number and position of the unit among the data units.
  logic                          d2_valid;
  logic [r5am_pkg::SECTOR_W-1:0] stripe;
  logic [r5am_pkg::SPU_W-1:0]    pos;
  logic [r5am_pkg::SIDE_W-1:0]   d2_side;

  r5am_div u_div_stripe (
    .clk(clk), .rst(rst),
    .in_valid(d1_valid),
    .dividend(unit),
    .divisor({{(r5am_pkg::SPU_W-r5am_pkg::ND_W){1'b0}}, ndata}),
    .side_in({{(r5am_pkg::SIDE_W-r5am_pkg::SPU_W){1'b0}}, offset}),
    .out_valid(d2_valid),
    .quot(stripe),
    .rem(pos),
    .side_out(d2_side)
  );

  // Rotation of the stripe. Since unit = stripe*(n-1) + pos, the data disk
  // is (pos - rot) mod n, which saves a separate unit-mod-n divider.
  logic                          d3_valid;
  logic [r5am_pkg::SPU_W-1:0]    rot_full;
  logic [r5am_pkg::SIDE_W-1:0]   d3_side;

  r5am_div u_div_rot (
    .clk(clk), .rst(rst),
    .in_valid(d2_valid),
    .dividend(stripe),
    .divisor({{(r5am_pkg::SPU_W-r5am_pkg::ND_W){1'b0}}, nd_eff}),
    .side_in({pos[r5am_pkg::COL_W-1:0], d2_side[r5am_pkg::SPU_W-1:0], stripe}),
    .out_valid(d3_valid),
    .quot(),
    .rem(rot_full),
    .side_out(d3_side)
  );

  // Multiply stage.
  logic                          m_valid;
  logic [r5am_pkg::SECTOR_W-1:0] m_prod;
  logic [r5am_pkg::SPU_W-1:0]    m_off;
  logic [r5am_pkg::ND_W-1:0]     m_pos;
  logic [r5am_pkg::ND_W-1:0]     m_rot;
  logic [r5am_pkg::SECTOR_W+r5am_pkg::SPU_W-1:0] prod_full;

  assign prod_full = d3_side[r5am_pkg::SECTOR_W-1:0] * spu_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    m_prod <= prod_full[r5am_pkg::SECTOR_W-1:0];
    m_off  <= d3_side[r5am_pkg::SECTOR_W +: r5am_pkg::SPU_W];
    m_pos  <= {1'b0, d3_side[r5am_pkg::SIDE_W-1 -: r5am_pkg::COL_W]};
    m_rot  <= rot_full[r5am_pkg::ND_W-1:0];
  end

  // Output stage.
  logic [r5am_pkg::ND_W-1:0] data_next;
  logic [r5am_pkg::ND_W-1:0] parity_next;
  logic [r5am_pkg::ND_W-1:0] first_next;

  always_comb begin
    if (m_pos >= m_rot) begin
      data_next = m_pos - m_rot;
    end else begin
      data_next = m_pos + nd_eff - m_rot;
    end
    parity_next = ndata - m_rot;
    first_next  = (m_rot == '0) ? '0 : nd_eff - m_rot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    disk_sector       <= m_prod + {{(r5am_pkg::SECTOR_W-r5am_pkg::SPU_W){1'b0}}, m_off};
    data_col          <= data_next[r5am_pkg::COL_W-1:0];
    parity_col        <= parity_next[r5am_pkg::COL_W-1:0];
    stripe_first_disk <= first_next[r5am_pkg::COL_W-1:0];
  end

endmodule

### src/r5am_checker.sv
// Port-level checks on the RAID 5 address map: fixed latency and no backpressure.
// Depends on r5am_pkg; bound to raid5_address_map below.
module r5am_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int LATENCY = 3 * r5am_pkg::DIV_STAGES + 2;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LATENCY !done)
    else $error("result without a transaction");

endmodule

bind raid5_address_map r5am_checker u_r5am_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
